FILE: sv/erlm_pkg.sv
// shared types and codes of the event ready-list manager
package erlm_pkg;

  localparam logic [2:0] OP_ALLOC    = 3'd0;
  localparam logic [2:0] OP_NOTIFY   = 3'd1;
  localparam logic [2:0] OP_CLOSE    = 3'd2;
  localparam logic [2:0] OP_POLL     = 3'd3;
  localparam logic [2:0] OP_LISTEN   = 3'd4;
  localparam logic [2:0] OP_UNLISTEN = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFD  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LATCH,
    CMD_RD,
    CMD_EXEC,
    CMD_ALLOC_RD,
    CMD_ALLOC_NEW,
    CMD_ALLOC_FREE,
    CMD_FULL,
    CMD_POLL_RD,
    CMD_POLL_POP,
    CMD_POLL_END
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic free_nz;
    logic hm_room;
    logic poll_more;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/erlm_ctrl.sv
// sequencer for table operations and the poll walk
module erlm_ctrl import erlm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [2:0] operation,
  input  sts_t       sts,
  output logic       in_stall,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_EXEC, S_ALLOC, S_ALLOC2, S_POLL, S_POP
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = CMD_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd = CMD_CLEAR;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd = CMD_LATCH;
          unique case (operation)
            OP_ALLOC: state_next = S_ALLOC;
            OP_POLL: state_next = S_POLL;
            OP_NOTIFY, OP_CLOSE, OP_LISTEN, OP_UNLISTEN: state_next = S_READ;
            default: state_next = S_EXEC;
          endcase
        end
      end
      S_READ: begin
        cmd = CMD_RD;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd = CMD_EXEC;
          state_next = S_IDLE;
        end
      end
      S_ALLOC: begin
        if (sts.free_nz) begin
          cmd = CMD_ALLOC_RD;
          state_next = S_ALLOC2;
        end else if (sts.out_free) begin
          cmd = sts.hm_room ? CMD_ALLOC_NEW : CMD_FULL;
          state_next = S_IDLE;
        end
      end
      S_ALLOC2: begin
        if (sts.out_free) begin
          cmd = CMD_ALLOC_FREE;
          state_next = S_IDLE;
        end
      end
      S_POLL: begin
        if (sts.poll_more) begin
          cmd = CMD_POLL_RD;
          state_next = S_POP;
        end else if (sts.out_free) begin
          cmd = CMD_POLL_END;
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        if (sts.out_free) begin
          cmd = CMD_POLL_POP;
          state_next = S_POLL;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      in_stall <= 1'b1;
    end else begin
      state <= state_next;
      in_stall <= (state_next != S_IDLE);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_LATCH) |-> (state == S_IDLE && !in_stall))
    else $error("item taken outside idle");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> $past(cmd == CMD_POLL_RD || cmd == CMD_NONE))
    else $error("pop without a head read");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ALLOC2) |-> $past(state == S_ALLOC || state == S_ALLOC2))
    else $error("free-list take out of order");

endmodule

FILE: sv/erlm_dp.sv
// descriptor table, ready list, free list and result register
module erlm_dp import erlm_pkg::*; #(
  parameter int DESCRIPTOR_COUNT = 64,
  parameter int MASK_WIDTH = 8,
  parameter int MAX_POLL_EVENTS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic [2:0] operation,
  input  logic [5:0] descriptor,
  input  logic [7:0] event_mask,
  input  logic [5:0] max_events,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_descriptor,
  output logic [7:0] out_mask,
  output logic [1:0] status,
  output logic       last
);

  localparam int AW = $clog2(DESCRIPTOR_COUNT);
  localparam int CW = $clog2(DESCRIPTOR_COUNT + 1);
  localparam int MW = MASK_WIDTH;
  localparam int LW = $clog2(MAX_POLL_EVENTS + 1);
  localparam int IW = 2 + 2 * MW;

  // entry layout: open, queued, listen, active
  logic [IW-1:0] info_mem [DESCRIPTOR_COUNT];
  logic [AW-1:0] next_mem [DESCRIPTOR_COUNT];
  logic [AW-1:0] prev_mem [DESCRIPTOR_COUNT];
  logic [AW-1:0] free_mem [DESCRIPTOR_COUNT];

  logic [IW-1:0] info_rd;
  logic [AW-1:0] next_rd, prev_rd, free_rd;

  logic [2:0]    op_r;
  logic [AW-1:0] fd_r;
  logic          fd_ok;
  logic [MW-1:0] m_r;
  logic [LW-1:0] lim_r, n_r;
  logic [AW-1:0] clr_idx, head, tail, hm, fhead;
  logic [CW-1:0] cnt, fcnt;
  logic          pend_v;
  logic [AW-1:0] pend_d;
  logic [MW-1:0] pend_m;

  logic          e_open, e_q;
  logic [MW-1:0] e_l, e_a, rm;
  logic          known, live, enq, unl, free_push, hm_dec;
  logic [AW-1:0] ftail;
  logic [LW-1:0] lim_in;

  logic          info_we, next_we, prev_we, free_we, rd_re, free_re;
  logic [AW-1:0] info_wa, next_wa, prev_wa, rd_ra;
  logic [IW-1:0] info_wd;
  logic [AW-1:0] next_wd, prev_wd;
  logic          emit, em_l;
  logic [AW-1:0] em_d;
  logic [MW-1:0] em_m;
  logic [1:0]    em_s;

  assign e_open = info_rd[IW-1];
  assign e_q    = info_rd[IW-2];
  assign e_l    = info_rd[2*MW-1:MW];
  assign e_a    = info_rd[MW-1:0];
  assign rm     = e_l & e_a;

  assign known = (op_r == OP_NOTIFY) || (op_r == OP_CLOSE) ||
                 (op_r == OP_LISTEN) || (op_r == OP_UNLISTEN);
  assign live  = known && fd_ok && e_open;
  assign enq   = live && !e_q &&
                 (((op_r == OP_NOTIFY) && ((e_l & m_r) != '0)) ||
                  ((op_r == OP_LISTEN) && (((e_l | m_r) & e_a) != '0)));
  assign unl   = live && (op_r == OP_CLOSE) && e_q;
  assign hm_dec    = live && (op_r == OP_CLOSE) && (fd_r == hm);
  assign free_push = live && (op_r == OP_CLOSE) && (fd_r != hm) &&
                     (int'(fcnt) < DESCRIPTOR_COUNT);

  always_comb begin
    int t;
    t = int'(fhead) + int'(fcnt);
    if (t >= DESCRIPTOR_COUNT) t = t - DESCRIPTOR_COUNT;
    ftail = AW'(t);
  end

  always_comb begin
    if (max_events == 6'd0) lim_in = LW'(1);
    else if (int'(max_events) > MAX_POLL_EVENTS) lim_in = LW'(MAX_POLL_EVENTS);
    else lim_in = LW'(max_events);
  end

  always_comb begin
    info_we = 1'b0; info_wa = fd_r; info_wd = '0;
    next_we = 1'b0; next_wa = tail; next_wd = fd_r;
    prev_we = 1'b0; prev_wa = fd_r; prev_wd = tail;
    free_we = free_push && (cmd == CMD_EXEC);
    rd_re = 1'b0; rd_ra = fd_r;
    free_re = (cmd == CMD_ALLOC_RD);
    emit = 1'b0; em_d = '0; em_m = '0; em_s = ST_OK; em_l = 1'b1;
    case (cmd)
      CMD_CLEAR: begin
        info_we = 1'b1;
        info_wa = clr_idx;
      end
      CMD_RD: rd_re = 1'b1;
      CMD_EXEC: begin
        emit = 1'b1;
        if (!known) begin
          em_d = '0;
        end else if (!live) begin
          em_d = fd_r;
          em_s = ST_NOFD;
        end else begin
          em_d = fd_r;
          info_we = 1'b1;
          case (op_r)
            OP_NOTIFY: info_wd = {1'b1, e_q | enq, e_l, e_a | m_r};
            OP_LISTEN: info_wd = {1'b1, e_q | enq, e_l | m_r, e_a};
            OP_UNLISTEN: info_wd = {1'b1, e_q, e_l & ~m_r, e_a};
            default: info_wd = '0;
          endcase
          if (enq && cnt != '0) begin
            next_we = 1'b1;
            prev_we = 1'b1;
          end
          if (unl) begin
            next_wa = prev_rd;
            next_wd = next_rd;
            next_we = (head != fd_r);
            prev_wa = next_rd;
            prev_wd = prev_rd;
            prev_we = (tail != fd_r);
          end
        end
      end
      CMD_ALLOC_NEW: begin
        info_we = 1'b1;
        info_wa = hm + AW'(1);
        info_wd = {1'b1, {(IW-1){1'b0}}};
        emit = 1'b1;
        em_d = hm + AW'(1);
      end
      CMD_ALLOC_FREE: begin
        info_we = 1'b1;
        info_wa = free_rd;
        info_wd = {1'b1, {(IW-1){1'b0}}};
        emit = 1'b1;
        em_d = free_rd;
      end
      CMD_FULL: begin
        emit = 1'b1;
        em_s = ST_FULL;
      end
      CMD_POLL_RD: begin
        rd_re = 1'b1;
        rd_ra = head;
      end
      CMD_POLL_POP: begin
        info_we = 1'b1;
        info_wa = head;
        info_wd = {e_open, 1'b0, e_l, e_a & ~rm};
        if (rm != '0 && pend_v) begin
          emit = 1'b1;
          em_d = pend_d;
          em_m = pend_m;
          em_l = 1'b0;
        end
      end
      CMD_POLL_END: begin
        emit = 1'b1;
        if (pend_v) begin
          em_d = pend_d;
          em_m = pend_m;
        end else begin
          em_s = ST_EMPTY;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (info_we) info_mem[info_wa] <= info_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (free_we) free_mem[ftail] <= fd_r;
    if (rd_re) begin
      info_rd <= info_mem[rd_ra];
      next_rd <= next_mem[rd_ra];
      prev_rd <= prev_mem[rd_ra];
    end
    if (free_re) free_rd <= free_mem[fhead];
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_LATCH) begin
      op_r  <= operation;
      fd_r  <= AW'(descriptor);
      fd_ok <= (int'(descriptor) < DESCRIPTOR_COUNT);
      m_r   <= MW'(event_mask);
      lim_r <= lim_in;
    end
    if (cmd == CMD_POLL_POP && rm != '0) begin
      pend_d <= head;
      pend_m <= rm;
    end
    if (emit) begin
      out_descriptor <= 6'(em_d);
      out_mask <= 8'(em_m);
      status <= em_s;
      last <= em_l;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      head <= '0;
      tail <= '0;
      cnt <= '0;
      hm <= '0;
      fhead <= '0;
      fcnt <= '0;
      n_r <= '0;
      pend_v <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (cmd)
        CMD_CLEAR: clr_idx <= clr_idx + AW'(1);
        CMD_LATCH: begin
          n_r <= '0;
          pend_v <= 1'b0;
        end
        CMD_EXEC: begin
          if (enq) begin
            if (cnt == '0) head <= fd_r;
            tail <= fd_r;
            cnt <= cnt + CW'(1);
          end
          if (unl) begin
            if (head == fd_r) head <= next_rd;
            if (tail == fd_r) tail <= prev_rd;
            cnt <= cnt - CW'(1);
          end
          if (hm_dec) hm <= hm - AW'(1);
          if (free_push) fcnt <= fcnt + CW'(1);
        end
        CMD_ALLOC_NEW: hm <= hm + AW'(1);
        CMD_ALLOC_FREE: begin
          fhead <= (int'(fhead) + 1 >= DESCRIPTOR_COUNT) ? '0 : fhead + AW'(1);
          fcnt <= fcnt - CW'(1);
        end
        CMD_POLL_POP: begin
          head <= next_rd;
          cnt <= cnt - CW'(1);
          if (rm != '0) begin
            pend_v <= 1'b1;
            n_r <= n_r + LW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign sts.clear_done = (int'(clr_idx) == DESCRIPTOR_COUNT - 1);
  assign sts.free_nz    = (fcnt != '0);
  assign sts.hm_room    = (int'(hm) + 1 < DESCRIPTOR_COUNT);
  assign sts.poll_more  = (cnt != '0) && (n_r < lim_r);
  assign sts.out_free   = !out_valid || !out_stall;

  assert property (@(posedge clk) disable iff (rst)
    int'(cnt) < DESCRIPTOR_COUNT)
    else $error("ready list overfull");
  assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || !out_stall))
    else $error("result overwrites a waiting transfer");
  assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_POLL_POP) |-> (cnt != '0))
    else $error("pop from empty ready list");

endmodule

FILE: sv/event_ready_list_manager.sv
// event ready-list manager top level
// notify/close/listen/unlisten read the descriptor entry before executing;
// poll reads and pops each ready-list entry walked; one item at a time
// the input is stalled until the item's last result sits in the output register
// after reset the descriptor table is cleared while the input is stalled
// results leave through one output register and wait there while stalled
module event_ready_list_manager import erlm_pkg::*; #(
  parameter int DESCRIPTOR_COUNT = 64,
  parameter int MASK_WIDTH = 8,
  parameter int MAX_POLL_EVENTS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] operation,
  input  logic [5:0] descriptor,
  input  logic [7:0] event_mask,
  input  logic [5:0] max_events,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_descriptor,
  output logic [7:0] out_mask,
  output logic [1:0] status,
  output logic       last
);

  cmd_t cmd;
  sts_t sts;

  erlm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .operation(operation),
    .sts(sts), .in_stall(in_stall), .cmd(cmd)
  );

  erlm_dp #(
    .DESCRIPTOR_COUNT(DESCRIPTOR_COUNT),
    .MASK_WIDTH(MASK_WIDTH),
    .MAX_POLL_EVENTS(MAX_POLL_EVENTS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .operation(operation), .descriptor(descriptor),
    .event_mask(event_mask), .max_events(max_events),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_descriptor(out_descriptor), .out_mask(out_mask),
    .status(status), .last(last)
  );

endmodule
